// ----- rtl/core/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and codes for the key/value table engine: request and
// response words, cell write controls and operation codes.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 9;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] OP_UPDATE   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_UPSERT   = 3'd2;
  localparam logic [FUNC_W-1:0] OP_ERASE    = 3'd3;
  localparam logic [FUNC_W-1:0] OP_FIND_KEY = 3'd4;
  localparam logic [FUNC_W-1:0] OP_FIND_POS = 3'd5;

  // cells per first-level reduction group
  localparam int GRP = 16;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  new_value;
    logic [POS_W-1:0]  position;
  } kvt_req_t;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] out_key;
    logic [VAL_W-1:0] out_value;
    logic [CNT_W-1:0] count;
  } kvt_rsp_t;

  // write controls broadcast to every cell
  typedef struct packed {
    logic append;
    logic update;
    logic erase;
  } kvt_apply_t;

endpackage

// ----- rtl/core/kvt_cell.sv -----
// ----------------------------------------------------------------------------
// kvt_cell
// One table entry: holds a key and value, compares against the broadcast
// request, and takes its upper neighbor's entry during an erase shift.
// ----------------------------------------------------------------------------
module kvt_cell #(
  parameter int INDEX    = 0,
  parameter int CNT_BITS = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmp_en,
  input  kvt_pkg::kvt_req_t         req,
  input  logic                      use_pos,
  input  logic [CNT_BITS-1:0]       count,
  input  kvt_pkg::kvt_apply_t       apply,
  input  logic [CNT_BITS-1:0]       hit_pos,
  input  logic [kvt_pkg::KEY_W-1:0] nb_key,
  input  logic [kvt_pkg::VAL_W-1:0] nb_val,
  output logic [kvt_pkg::KEY_W-1:0] key_q,
  output logic [kvt_pkg::VAL_W-1:0] val_q,
  output logic                      hit
);
  import kvt_pkg::*;

  localparam int PW = (CNT_BITS > POS_W) ? CNT_BITS : POS_W;
  localparam logic [CNT_BITS-1:0] ME  = CNT_BITS'(INDEX);
  localparam logic [CNT_BITS-1:0] ME1 = CNT_BITS'(INDEX + 1);
  localparam logic [PW-1:0]       MEP = PW'(INDEX);

  logic live;
  logic pos_eq;

  assign live   = ME < count;
  assign pos_eq = PW'(req.position) == MEP;

  // match flag, held until the next compare
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmp_en) begin
      hit <= live && (use_pos ? pos_eq : (key_q == req.key));
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    priority if (apply.append && (ME == count)) begin
      key_q <= req.key;
      val_q <= req.new_value;
    end else if (apply.update && hit) begin
      val_q <= req.new_value;
    end else if (apply.erase && (ME >= hit_pos) && (ME1 < count)) begin
      key_q <= nb_key;
      val_q <= nb_val;
    end else begin
      // no write this cycle
      key_q <= key_q;
      val_q <= val_q;
    end
  end

endmodule

// ----- rtl/core/kvt_or_tree.sv -----
// ----------------------------------------------------------------------------
// kvt_or_tree
// Registered one-hot reduction: flags whether any input hit and passes on
// the data word of the hitting input.
// ----------------------------------------------------------------------------
module kvt_or_tree #(
  parameter int N = 16,
  parameter int W = 72
) (
  input  logic                clk,
  input  logic [N-1:0]        hit,
  input  logic [N-1:0][W-1:0] data,
  output logic                any,
  output logic [W-1:0]        sel
);

  logic         any_c;
  logic [W-1:0] sel_c;

  // at most one hit, so an AND-OR select is exact
  always_comb begin
    any_c = 1'b0;
    sel_c = '0;
    for (int i = 0; i < N; i++) begin
      any_c = any_c | hit[i];
      sel_c = sel_c | (data[i] & {W{hit[i]}});
    end
  end

  always_ff @(posedge clk) begin
    any <= any_c;
    sel <= sel_c;
  end

endmodule

// ----- rtl/core/key_value_table_engine.sv -----
// ----------------------------------------------------------------------------
// key_value_table_engine
// An accepted request word passes through compare, group reduce, final
// reduce and apply in turn; apply waits while the response is stalled.
// A new request is taken only back in idle; the compare/reduce chain serves
// one request at a time.
// Reset: synchronous rst empties the table and clears the handshakes; cell
// contents are not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
module key_value_table_engine #(
  parameter int CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  kvt_pkg::kvt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output kvt_pkg::kvt_rsp_t rsp
);
  import kvt_pkg::*;

  localparam int IDX_BITS = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
  localparam int NPAD     = NGRP * GRP;
  localparam int DW       = IDX_BITS + KEY_W + VAL_W;
  localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_GRP   = 3'd2;
  localparam logic [2:0] S_ALL   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  kvt_req_t            req_q;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;

  logic                cmp_en;
  logic                use_pos;
  logic                fire;
  kvt_apply_t          apply;

  logic [NPAD-1:0]          hit_all;
  logic [NPAD-1:0][DW-1:0]  dat_all;
  logic [CAPACITY-1:0][KEY_W-1:0] cell_key;
  logic [CAPACITY-1:0][VAL_W-1:0] cell_val;

  logic [NGRP-1:0]          g_any;
  logic [NGRP-1:0][DW-1:0]  g_dat;
  logic                     found;
  logic [DW-1:0]            f_dat;
  logic [IDX_BITS-1:0]      hit_idx;
  logic [CNT_BITS-1:0]      hit_pos;
  logic [KEY_W-1:0]         hit_key;
  logic [VAL_W-1:0]         hit_val;
  kvt_rsp_t                 rsp_next;

  assign req_ready = (state == S_IDLE);
  assign cmp_en    = (state == S_CMP);
  assign use_pos   = (req_q.func == OP_FIND_POS);
  assign fire      = (state == S_APPLY) && (!rsp_valid || rsp_ready);

  assign hit_idx = f_dat[DW-1 -: IDX_BITS];
  assign hit_key = f_dat[KEY_W+VAL_W-1 -: KEY_W];
  assign hit_val = f_dat[VAL_W-1:0];
  assign hit_pos = CNT_BITS'(hit_idx);

  // request capture
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_CMP;
      S_CMP:   state_next = S_GRP;
      S_GRP:   state_next = S_ALL;
      S_ALL:   state_next = S_APPLY;
      S_APPLY: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row of cells
  for (genvar i = 0; i < NPAD; i++) begin : g_cell
    if (i < CAPACITY) begin : g_live
      logic [KEY_W-1:0] nb_key;
      logic [VAL_W-1:0] nb_val;
      if (i < CAPACITY - 1) begin : g_nb
        assign nb_key = cell_key[i+1];
        assign nb_val = cell_val[i+1];
      end else begin : g_top
        assign nb_key = cell_key[i];
        assign nb_val = cell_val[i];
      end
      kvt_cell #(
        .INDEX    (i),
        .CNT_BITS (CNT_BITS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .cmp_en  (cmp_en),
        .req     (req_q),
        .use_pos (use_pos),
        .count   (count),
        .apply   (apply),
        .hit_pos (hit_pos),
        .nb_key  (nb_key),
        .nb_val  (nb_val),
        .key_q   (cell_key[i]),
        .val_q   (cell_val[i]),
        .hit     (hit_all[i])
      );
      assign dat_all[i] = {IDX_BITS'(i), cell_key[i], cell_val[i]};
    end else begin : g_pad
      assign hit_all[i] = 1'b0;
      assign dat_all[i] = '0;
    end
  end

  // two-level match reduction
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    kvt_or_tree #(
      .N (GRP),
      .W (DW)
    ) u_grp (
      .clk  (clk),
      .hit  (hit_all[g*GRP +: GRP]),
      .data (dat_all[g*GRP +: GRP]),
      .any  (g_any[g]),
      .sel  (g_dat[g])
    );
  end

  kvt_or_tree #(
    .N (NGRP),
    .W (DW)
  ) u_all (
    .clk  (clk),
    .hit  (g_any),
    .data (g_dat),
    .any  (found),
    .sel  (f_dat)
  );

  // operation decode and result
  always_comb begin
    apply      = '0;
    count_next = count;
    rsp_next   = '0;
    unique case (req_q.func)
      OP_INSERT: begin
        if (!found && (count != FULL)) begin
          apply.append = 1'b1;
          count_next   = count + 1'b1;
          rsp_next.ok  = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (found) begin
          apply.update = 1'b1;
          rsp_next.ok  = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (found) begin
          apply.update = 1'b1;
          rsp_next.ok  = 1'b1;
        end else if (count != FULL) begin
          apply.append = 1'b1;
          count_next   = count + 1'b1;
          rsp_next.ok  = 1'b1;
        end
      end
      OP_ERASE: begin
        if (found) begin
          apply.erase = 1'b1;
          count_next  = count - 1'b1;
          rsp_next.ok = 1'b1;
        end
      end
      OP_FIND_KEY: begin
        if (found) begin
          rsp_next.ok        = 1'b1;
          rsp_next.out_value = hit_val;
        end
      end
      OP_FIND_POS: begin
        if (found) begin
          rsp_next.ok        = 1'b1;
          rsp_next.out_key   = hit_key;
          rsp_next.out_value = hit_val;
        end
      end
      default: begin
      end
    endcase
    rsp_next.count = CNT_W'(count_next);
    if (!fire) begin
      apply      = '0;
      count_next = count;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/core/kvt_checker.sv -----
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks for the key/value table engine, bound to the top level.
// ----------------------------------------------------------------------------
module kvt_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input kvt_pkg::kvt_rsp_t rsp
);

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one request in flight: ready drops after an accept
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request accepted while busy");

  // a failed operation reports no key and no value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> (rsp.out_key == '0) && (rsp.out_value == '0))
    else $error("failed response carries data");

  // a new response only comes while a request is being worked on
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response without a request in flight");

endmodule

bind key_value_table_engine kvt_checker u_kvt_checker (.*);
